FILE: rtl/truncated_taylor_sin_cos_assert.svh
// Assertion macros for the truncated Taylor sine/cosine block.
// Included by the port checker; needs nothing else.
`ifndef TRUNCATED_TAYLOR_SIN_COS_ASSERT_SVH
`define TRUNCATED_TAYLOR_SIN_COS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define TTSC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttsc assertion failed");

// Next-cycle implication, disabled while reset is held
`define TTSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttsc assertion failed");

// Next-cycle implication that also holds across reset
`define TTSC_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ttsc assertion failed");

`endif

FILE: rtl/ttsc_pkg.sv
// Shared constants, types and helpers for the truncated Taylor sine/cosine block.
// Used by ttsc_mul, ttsc_div and truncated_taylor_sin_cos; depends on nothing.
`default_nettype none

package ttsc_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int ANGLE_W    = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_W      = 3;
    localparam int MAX_TERMS  = 6;
    localparam int K_W        = 4;
    localparam int TERM_W     = 48;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 52;
    localparam int DIV_W      = 56;
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int REM_W      = K_W;

    localparam logic [TERM_W-1:0] ONE_TERM   = TERM_W'(1) << FRAC_BITS;
    localparam logic [TERM_W-1:0] TERM_LIMIT = TERM_W'(1) << (TERM_W - 2);
    localparam logic [ACC_W-1:0]  ONE_ACC    = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -ACC_OUT_MAX - ACC_W'(1);

    // Request to the shared divider
    typedef struct packed {
        logic           start;
        logic [K_W-1:0] divisor;
    } div_req_t;

    // Index of the last chain term, 2n-1, with n forced into 1..MAX_TERMS
    function automatic logic [K_W-1:0] last_index(input logic [CFG_W-1:0] tc);
        logic [K_W-1:0] n;
        n = K_W'(tc);
        if (n == '0) begin
            n = K_W'(1);
        end else if (n > K_W'(MAX_TERMS)) begin
            n = K_W'(MAX_TERMS);
        end
        return (n << 1) - K_W'(1);
    endfunction

    // Saturate an accumulator to the output range
    function automatic logic [OUT_W-1:0] clamp_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > ACC_OUT_MAX) begin
            c = ACC_OUT_MAX;
        end else if (v < ACC_OUT_MIN) begin
            c = ACC_OUT_MIN;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ttsc_mul.sv
// Shared multiplier: one chain term times the angle, product registered.
// Depends on ttsc_pkg.
`default_nettype none

module ttsc_mul
    import ttsc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [TERM_W-1:0]  term,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic signed [PROD_W-1:0]      prod_reg
);

    logic signed [PROD_W-1:0] term_ext;
    logic signed [PROD_W-1:0] angle_ext;

    assign term_ext  = {{(PROD_W - TERM_W){term[TERM_W-1]}}, term};
    assign angle_ext = {{(PROD_W - ANGLE_W){angle[ANGLE_W-1]}}, angle};

    // Capture the product when the sequencer asks for it
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= term_ext * angle_ext;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ttsc_div.sv
// Digit-serial divider of a wide magnitude by a small divisor (1..11).
// Restoring, DIV_STEP quotient bits per cycle. Depends on ttsc_pkg.
`default_nettype none

module ttsc_div
    import ttsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire div_req_t         req,
    input  wire logic [DIV_W-1:0] dividend,
    output logic [DIV_W-1:0]      quotient,
    output logic                  done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [K_W-1:0]       divisor_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     sh_reg;
    logic [REM_W-1:0]     rem_next;
    logic [DIV_W-1:0]     sh_next;

    // One chunk of restoring steps: shift a dividend bit in, subtract if it fits
    always_comb begin
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial   = {rem_next, sh_next[DIV_W-1]};
            sh_next = sh_next << 1;
            diff    = trial - {1'b0, divisor_reg};
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next   = diff[REM_W-1:0];
                sh_next[0] = 1'b1;
            end else begin
                rem_next = trial[REM_W-1:0];
            end
        end
    end

    // Load on start, advance one chunk per cycle, pulse done after the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg    <= 1'b1;
                sh_reg      <= dividend;
                rem_reg     <= '0;
                cnt_reg     <= '0;
                divisor_reg <= req.divisor;
            end else if (busy_reg) begin
                sh_reg  <= sh_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: rtl/truncated_taylor_sin_cos.sv
// Truncated Taylor-series sine and cosine of one Q3.12 angle per word.
// Top level: sequencer, accumulators, output register. Depends on ttsc_pkg,
// ttsc_mul and ttsc_div.
//
// Usage:
//   s_tdata carries one angle; it is taken when s_tvalid and s_tready are high.
//   m_tdata returns sine and cosine (Q11.12, saturated) for that angle.
//   cfg_wr_en/cfg_wr_data write term_count n (0 acts as 1, above 6 as 6);
//   write it only while no angle is in flight.
// Sequence:
//   The chain t(k) = round(t(k-1) * x / k) runs for k = 1 .. 2n-1 through one
//   shared multiplier and one shared 8-bit-per-cycle divider. Each term goes
//   through load, the divider's chunks, a wait to see done, and accumulate.
//   The next angle is taken only once the result of the last one has been
//   written to the output register; s_tready is high only while the block
//   is idle.
// Reset and stalls:
//   Reset returns the sequencer to idle, drops m_tvalid and sets n to 6.
//   A finished result waits in the output register while m_tready is low;
//   the next angle is accepted and computed meanwhile, and holds before its
//   result is written until the register has been emptied.
`default_nettype none

module truncated_taylor_sin_cos
    import ttsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,   // term_count
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [ANGLE_W-1:0]   s_tdata,       // [15:0] angle
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2*OUT_W-1:0]        m_tdata        // [23:0] sine_value, [47:24] cosine_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_ACC,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [CFG_W-1:0]          term_count_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [K_W-1:0]            k_reg;
    logic [K_W-1:0]            last_reg;
    logic signed [TERM_W-1:0]  t_reg;
    logic signed [ACC_W-1:0]   sin_acc_reg;
    logic signed [ACC_W-1:0]   cos_acc_reg;
    logic                      m_tvalid_reg;
    logic [2*OUT_W-1:0]        m_tdata_reg;

    logic                      mul_en;
    logic signed [PROD_W-1:0]  prod;
    logic                      prod_neg;
    logic [PROD_W-1:0]         round_add;
    logic [PROD_W-1:0]         y_sum;
    logic [DIV_W-1:0]          dividend;
    logic [DIV_W-1:0]          quotient;
    logic                      div_done;
    div_req_t                  div_req;
    logic [TERM_W-1:0]         q_sat;
    logic signed [TERM_W-1:0]  t_new;
    logic signed [TERM_W-1:0]  signed_term;
    logic signed [ACC_W-1:0]   term_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Multiply the current term by the angle on entry and in each accumulate but the last
    assign mul_en = (state_reg == S_MUL) || ((state_reg == S_ACC) && (k_reg != last_reg));

    ttsc_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .term     (t_reg),
        .angle    (angle_reg),
        .prod_reg (prod)
    );

    // Magnitude plus half the divisor, then drop the fraction bits
    always_comb begin
        prod_neg  = prod[PROD_W-1];
        round_add = PROD_W'(k_reg) << (FRAC_BITS - 1);
        if (prod_neg) begin
            y_sum = round_add + ~PROD_W'(prod) + PROD_W'(1);
        end else begin
            y_sum = PROD_W'(prod) + round_add;
        end
        dividend = DIV_W'(y_sum >> FRAC_BITS);
    end

    assign div_req = '{start: (state_reg == S_LOAD), divisor: k_reg};

    ttsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (dividend),
        .quotient (quotient),
        .done     (div_done)
    );

    // Saturate the quotient and restore the sign of the product
    always_comb begin
        if (quotient > DIV_W'(TERM_LIMIT)) begin
            q_sat = TERM_LIMIT;
        end else begin
            q_sat = quotient[TERM_W-1:0];
        end
        t_new = prod_neg ? -$signed(q_sat) : $signed(q_sat);
    end

    // Alternate sign on every second term, widen for the accumulators
    always_comb begin
        signed_term = k_reg[1] ? -t_reg : t_reg;
        term_ext    = {{(ACC_W - TERM_W){signed_term[TERM_W-1]}}, signed_term};
    end

    // Sequencer, configuration register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            term_count_reg <= CFG_W'(MAX_TERMS);
        end else begin
            if (cfg_wr_en) begin
                term_count_reg <= cfg_wr_data;
            end
            // drop the word once taken, unless a new one replaces it below
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        angle_reg   <= s_tdata;
                        k_reg       <= K_W'(1);
                        last_reg    <= last_index(term_count_reg);
                        t_reg       <= ONE_TERM;
                        sin_acc_reg <= '0;
                        cos_acc_reg <= ONE_ACC;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        t_reg     <= t_new;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (k_reg[0]) begin
                        sin_acc_reg <= sin_acc_reg + term_ext;
                    end else begin
                        cos_acc_reg <= cos_acc_reg + term_ext;
                    end
                    if (k_reg == last_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {clamp_out(cos_acc_reg), clamp_out(sin_acc_reg)};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ttsc_checker.sv
// Port-level checker for truncated_taylor_sin_cos, attached by bind.
// Depends on truncated_taylor_sin_cos_assert.svh.
`default_nettype none

`include "truncated_taylor_sin_cos_assert.svh"

module ttsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // A word waiting on the result side stays until taken
    `TTSC_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The block is busy right after it takes an angle
    `TTSC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A result never appears in the cycle after an angle enters an empty block
    `TTSC_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // Reset empties the result side
    `TTSC_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)

endmodule

bind truncated_taylor_sin_cos ttsc_checker u_ttsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for truncated_taylor_sin_cos: angle words in, sine/cosine words out.
// Depends on ttsc_pkg and the block's RTL; a clocked driver, monitor and stall watchdog.

module tb_top;
    import ttsc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int MAX_REPORTS = 60;
    localparam longint unsigned TERM_CAP = 64'd1 << 46;

    // One angle together with the sine and cosine it should produce
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [OUT_W-1:0]   sine;
        logic [OUT_W-1:0]   cosine;
    } sincos_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ANGLE_W-1:0]   s_tdata = '0;      // [15:0] angle
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [2*OUT_W-1:0]   m_tdata;           // [23:0] sine_value, [47:24] cosine_value

    logic [ANGLE_W-1:0]   pending_angles [$];
    sincos_t              sincos_due [$];
    logic [CFG_W-1:0]     term_count_model = CFG_W'(MAX_TERMS);
    bit                   calm = 1'b0;
    int                   mismatch_count = 0;
    int                   stall_cycles = 0;

    truncated_taylor_sin_cos i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp a series sum to the signed 24-bit output range
    function automatic logic [OUT_W-1:0] sat_q11_12(input longint v);
        if (v > 64'sd8388607) begin
            return 24'h7FFFFF;
        end
        if (v < -64'sd8388608) begin
            return 24'h800000;
        end
        return v[OUT_W-1:0];
    endfunction

    // Run the rounded term chain t(k) = t(k-1) * x / k and fold it into both sums
    function automatic sincos_t taylor_sincos(input logic [ANGLE_W-1:0] angle,
                                              input logic [CFG_W-1:0] tc);
        sincos_t         r;
        longint          x;
        longint          t;
        longint          prod;
        longint          sin_acc;
        longint          cos_acc;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        int              terms;
        x = $signed(angle);
        terms = (tc == 0) ? 1 : (tc > MAX_TERMS) ? MAX_TERMS : int'(tc);
        t = longint'(1) <<< FRAC_BITS;
        sin_acc = 0;
        cos_acc = t;
        for (int k = 1; k <= 2 * terms - 1; k++) begin
            prod = t * x;
            mag = (prod < 0) ? -prod : prod;
            den = longint'(k) << FRAC_BITS;
            // round half away from zero, then hold the magnitude at the cap
            q = (mag + den / 2) / den;
            if (q > TERM_CAP) begin
                q = TERM_CAP;
            end
            t = (prod < 0) ? -longint'(q) : longint'(q);
            if (k[0]) begin
                sin_acc = k[1] ? sin_acc - t : sin_acc + t;
            end else begin
                cos_acc = k[1] ? cos_acc - t : cos_acc + t;
            end
        end
        r.angle = angle;
        r.sine = sat_q11_12(sin_acc);
        r.cosine = sat_q11_12(cos_acc);
        return r;
    endfunction

    // Driver: predict on each accepted word, hold a word until taken, idle at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sincos_due.push_back(taylor_sincos(s_tdata, term_count_model));
                void'(pending_angles.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the current word
            end else if (pending_angles.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_angles[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction, stall at random
    always @(posedge aclk) begin
        sincos_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sincos_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual sine %h cosine %h",
                                 $time, m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W]);
                    end
                end else begin
                    want = sincos_due.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want.sine) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: angle %h sine expected %h actual %h",
                                     $time, want.angle, want.sine, m_tdata[OUT_W-1:0]);
                        end
                    end
                    if (m_tdata[2*OUT_W-1:OUT_W] !== want.cosine) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: angle %h cosine expected %h actual %h",
                                     $time, want.angle, want.cosine, m_tdata[2*OUT_W-1:OUT_W]);
                        end
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Write term_count while the block is idle and track it in the predictor
    task automatic write_term_count(input logic [CFG_W-1:0] tc);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= tc;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        term_count_model = tc;
    endtask

    // Pause the sender until every word is taken and every result is back
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_angles.size() != 0 || s_tvalid || sincos_due.size() != 0);
    endtask

    initial begin
        logic [ANGLE_W-1:0] edge_angles [14];
        logic [ANGLE_W-1:0] corner_angles [4];
        logic [CFG_W-1:0]   random_counts [9];
        logic [ANGLE_W-1:0] ang;

        // Q3.12: 1.0, pi/2, pi, 2pi, 2.0 and the range ends
        edge_angles = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h1000,
                        16'hF000, 16'h1922, 16'hE6DE, 16'h3244, 16'h6488, 16'h2000,
                        16'h5555, 16'hAAAA};
        corner_angles = '{16'h7FFF, 16'h8000, 16'h1000, 16'h0000};
        random_counts = '{3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7, 3'd4, 3'd6};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: full series on the edge angles
        write_term_count(3'd6);
        @(negedge aclk);
        foreach (edge_angles[i]) pending_angles.push_back(edge_angles[i]);
        wait_drained();

        // Directed: zero count acts as one term, count above maximum as the maximum
        write_term_count(3'd0);
        @(negedge aclk);
        foreach (corner_angles[i]) pending_angles.push_back(corner_angles[i]);
        wait_drained();
        write_term_count(3'd7);
        @(negedge aclk);
        foreach (corner_angles[i]) pending_angles.push_back(corner_angles[i]);
        wait_drained();

        // Random: one drained phase per listed term count, one phase without idling
        foreach (random_counts[p]) begin
            write_term_count(random_counts[p]);
            calm = (p == 4);
            @(negedge aclk);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                case ($urandom_range(0, 3))
                    0, 1: ang = 16'($urandom_range(0, 65535));
                    2: ang = 16'($urandom_range(0, 25736)) - 16'd12868;
                    default: ang = 16'h7FFF ^ {16{1'($urandom_range(0, 1))}};
                endcase
                pending_angles.push_back(ang);
            end
            wait_drained();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && sincos_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
